// File: src/bdqs_pkg.sv
// ============================================================================
// bdqs_pkg
// Shared types and constants for the bounded deque with search.
// ============================================================================
`timescale 1ns / 1ps

package bdqs_pkg;

    // Payload widths
    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 6;
    localparam int OUT_TDATA_W   = 40;   // data_out + position, padded to bytes

    // Default number of entries
    localparam int DEFAULT_DEPTH = 64;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_BACK  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_SEARCH     = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SEARCH,
        S_EMIT
    } state_t;

endpackage

// File: src/bounded_deque_with_search_unit.sv
// ============================================================================
// bounded_deque_with_search_unit
// Bounded double-ended queue of signed 32-bit values with linear search.
//
// The queue holds up to DEPTH values in a circular RAM tracked by a front
// pointer and an entry count. A request (tuser = function, tdata = value)
// inserts at the front, appends at the back, removes the front value, or
// searches from the front for the first equal value. One request is in work
// at a time and produces exactly one result transfer. An insert goes from
// the transfer to S_EMIT, a remove passes through S_POP for its RAM read,
// and a search stays in S_SEARCH while comparing k entries (k in 1..entry
// count) one at a time, paced by the single RAM read port feeding one
// 32-bit comparator, so a full queue is the worst case. S_EMIT waits for a
// free output register, and the finished result sits there so the next
// request can be taken while it waits. No clearing pass is needed after
// reset: only entries inside the count are ever read.
// ============================================================================
`timescale 1ns / 1ps

module bounded_deque_with_search_unit #(
    parameter int DEPTH = bdqs_pkg::DEFAULT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bdqs_pkg::DATA_W-1:0]         s_axis_tdata,  // [31:0] value
    input  logic [bdqs_pkg::FUNC_W-1:0]         s_axis_tuser,  // [1:0] func
    // Result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bdqs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [31:0] data_out,
                                                               // [37:32] position,
                                                               // [39:38] zero
    output logic [bdqs_pkg::STATUS_W-1:0]       m_axis_tuser   // [1:0] status
);

    import bdqs_pkg::*;

    localparam int AW = $clog2(DEPTH);        // slot index width
    localparam int CW = $clog2(DEPTH + 1);    // entry count width
    localparam int SW = CW + 1;               // front + count sum width

    // ------------------------------------------------------------------------
    // Pointer helpers (wrap at DEPTH)
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    // ------------------------------------------------------------------------
    // Registers
    state_t                 state_reg,      state_next;
    logic [AW-1:0]          front_reg,      front_next;
    logic [CW-1:0]          count_reg,      count_next;
    logic [AW-1:0]          rptr_reg,       rptr_next;
    logic [AW-1:0]          cidx_reg,       cidx_next;
    logic [DATA_W-1:0]      key_reg,        key_next;
    status_t                res_status_reg, res_status_next;
    logic [DATA_W-1:0]      res_data_reg,   res_data_next;
    logic [POS_W-1:0]       res_pos_reg,    res_pos_next;
    logic                   out_valid_reg,  out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [DATA_W-1:0]      out_data_reg,   out_data_next;
    logic [POS_W-1:0]       out_pos_reg,    out_pos_next;

    // RAM port signals
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [DATA_W-1:0]      ram_rd_data;

    // Misc decode
    logic                   in_xfer;
    logic                   out_free;
    logic                   is_full;
    logic                   is_empty;
    logic [AW-1:0]          front_dec;
    logic [SW-1:0]          back_sum;
    logic [AW-1:0]          back_slot;
    func_t                  req_func;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign is_full       = (count_reg == CW'(DEPTH));
    assign is_empty      = (count_reg == '0);
    assign front_dec     = ptr_dec(front_reg);
    assign req_func      = func_t'(s_axis_tuser);

    // Back slot = (front + count) mod DEPTH, one compare and subtract
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                : AW'(back_sum);

    // ------------------------------------------------------------------------
    // Entry store
    bdqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------------
    // State and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        rptr_reg       <= rptr_next;
        cidx_reg       <= cidx_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_pos_reg    <= out_pos_next;
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state, RAM control, result capture
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        rptr_next       = rptr_reg;
        cidx_next       = cidx_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_pos_next    = res_pos_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_pos_next    = out_pos_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = front_dec;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    key_next      = s_axis_tdata;
                    res_data_next = '0;
                    res_pos_next  = '0;
                    unique case (req_func)
                        FUNC_PUSH_FRONT:
                        begin
                            state_next = S_EMIT;
                            if (is_full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_wr_en       = 1'b1;
                                ram_wr_addr     = front_dec;
                                front_next      = front_dec;
                                count_next      = count_reg + CW'(1);
                                res_status_next = STAT_OK;
                            end
                        end
                        FUNC_PUSH_BACK:
                        begin
                            state_next = S_EMIT;
                            if (is_full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_wr_en       = 1'b1;
                                ram_wr_addr     = back_slot;
                                count_next      = count_reg + CW'(1);
                                res_status_next = STAT_OK;
                            end
                        end
                        FUNC_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = STAT_EMPTY;
                                res_data_next   = '1;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = front_reg;
                                state_next  = S_POP;
                            end
                        end
                        FUNC_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = STAT_NOT_FOUND;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = front_reg;
                                rptr_next   = ptr_inc(front_reg);
                                cidx_next   = '0;
                                state_next  = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Front value arrives from the RAM
            S_POP:
            begin
                res_status_next = STAT_OK;
                res_data_next   = ram_rd_data;
                front_next      = ptr_inc(front_reg);
                count_next      = count_reg - CW'(1);
                state_next      = S_EMIT;
            end

            // One compare per cycle; next read is issued in parallel
            S_SEARCH:
            begin
                if (ram_rd_data == key_reg)
                begin
                    res_status_next = STAT_OK;
                    res_pos_next    = POS_W'(cidx_reg);
                    state_next      = S_EMIT;
                end
                else if ((CW'(cidx_reg) + CW'(1)) == count_reg)
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = S_EMIT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rptr_reg;
                    rptr_next   = ptr_inc(rptr_reg);
                    cidx_next   = cidx_reg + AW'(1);
                end
            end

            // Hand the result to the output register once it is free
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_pos_next    = res_pos_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Result channel
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - POS_W){1'b0}},
                            out_pos_reg, out_data_reg};

    // ------------------------------------------------------------------------
    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= AW'(DEPTH - 1))
        else $error("front pointer out of range");

    a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (CW'(cidx_reg) < count_reg))
        else $error("search index beyond entry count");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !is_full &&
         (req_func == FUNC_PUSH_FRONT || req_func == FUNC_PUSH_BACK))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the queue");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && !m_axis_tready)
        |=> (state_reg == S_EMIT))
        else $error("result dropped while output stalled");

endmodule

// File: src/bdqs_ram.sv
// ============================================================================
// bdqs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module bdqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sim/tb.sv
// ============================================================================
// tb
// Self-checking testbench for bounded_deque_with_search_unit.
//
// Requests go in on the slave stream (func in tuser, value in tdata). Each
// accepted request is run through a behavioral deque kept in the testbench,
// and its expected reply is queued. A separate process checks every reply
// transfer field by field against the oldest queued reply. Directed tests
// cover the empty and full edges, extreme values, duplicates and a search
// hit at the last position. A long random run follows, made of phases that
// grow, shrink or churn the queue, with random gaps on both sides.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    import bdqs_pkg::*;

    localparam int DEPTH          = DEFAULT_DEPTH;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int GAP_MAX        = 8;
    localparam int SETTLE_CYCLES  = DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int PHASE_ITEMS    = 100;
    localparam int PRINT_LIMIT    = 40;

    // One reply as seen on the result stream
    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   data_out;
        logic [POS_W-1:0]    position;
    } deque_reply_t;

    // Traffic mix of one random phase
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } mix_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [DATA_W-1:0]        s_axis_tdata;   // [31:0] value
    logic [FUNC_W-1:0]        s_axis_tuser;   // [1:0] func
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;   // [31:0] data_out, [37:32] position
    logic [STATUS_W-1:0]      m_axis_tuser;   // [1:0] status

    // Behavioral copy of the deque
    logic [DATA_W-1:0]        shadow_mem [DEPTH];
    int                       shadow_front;
    int                       shadow_count;

    deque_reply_t             pending_replies[$];
    bit                       send_gaps;
    bit                       reply_stalls;
    int                       mismatches;
    int                       replies_checked;
    int                       status_seen [4];
    int                       func_sent [4];
    int                       deepest_fill;

    bounded_deque_with_search_unit #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Apply one request to the shadow deque and return the reply it earns
    function automatic deque_reply_t deque_apply(func_t func, logic [DATA_W-1:0] value);
        deque_reply_t reply;
        int           i;
        reply        = '0;
        reply.status = STAT_OK;
        case (func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                    reply.status = STAT_FULL;
                else if (func == FUNC_PUSH_FRONT)
                begin
                    shadow_front             = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_mem[shadow_front] = value;
                    shadow_count++;
                end
                else
                begin
                    shadow_mem[(shadow_front + shadow_count) % DEPTH] = value;
                    shadow_count++;
                end
            end
            FUNC_POP_FRONT:
            begin
                if (shadow_count == 0)
                begin
                    reply.status   = STAT_EMPTY;
                    reply.data_out = '1;
                end
                else
                begin
                    reply.data_out = shadow_mem[shadow_front];
                    shadow_front   = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            end
            default:
            begin
                // first match from the front wins
                reply.status = STAT_NOT_FOUND;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_mem[(shadow_front + i) % DEPTH] == value)
                    begin
                        reply.status   = STAT_OK;
                        reply.position = POS_W'(i);
                        break;
                    end
                end
            end
        endcase
        if (shadow_count > deepest_fill)
            deepest_fill = shadow_count;
        return reply;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // Send one request; the reply is predicted at the accepting edge
    task automatic send_request(input func_t func, input logic [DATA_W-1:0] value);
        int gap;
        gap = send_gaps ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_replies.push_back(deque_apply(func, value));
        func_sent[func]++;
    endtask

    // Stop sending and wait for every outstanding reply
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3, 4, 5: return DATA_W'($urandom_range(0, 7));  // small pool, many duplicates
            default: return $urandom();
        endcase
    endfunction

    // Search keys mostly hit something currently stored
    function automatic logic [DATA_W-1:0] pick_key();
        int offset;
        if (shadow_count > 0 && $urandom_range(0, 2) != 0)
        begin
            offset = $urandom_range(0, shadow_count - 1);
            return shadow_mem[(shadow_front + offset) % DEPTH];
        end
        return pick_value();
    endfunction

    // Reply side: random stalls, one draw per transfer
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = reply_stalls ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Reply checker
    always @(posedge clk)
    begin : reply_check
        deque_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("reply transfer with no request outstanding");
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                status_seen[want.status]++;
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("reply %0d: status %0d, expected %0d",
                        replies_checked, m_axis_tuser, want.status));
                if (m_axis_tdata[DATA_W-1:0] !== want.data_out)
                    report_mismatch($sformatf("reply %0d: data_out %h, expected %h",
                        replies_checked, m_axis_tdata[DATA_W-1:0], want.data_out));
                if (m_axis_tdata[DATA_W +: POS_W] !== want.position)
                    report_mismatch($sformatf("reply %0d: position %0d, expected %0d",
                        replies_checked, m_axis_tdata[DATA_W +: POS_W], want.position));
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] timeout: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Remove and search on an empty queue
    task automatic test_empty_queue();
        send_request(FUNC_POP_FRONT, 32'h0);
        send_request(FUNC_SEARCH, 32'h0);
        send_request(FUNC_SEARCH, 32'hFFFF_FFFF);
    endtask

    // Extreme values, duplicates, hits and misses, drain past empty
    task automatic test_extremes();
        send_request(FUNC_PUSH_BACK,  32'h7FFF_FFFF);
        send_request(FUNC_PUSH_FRONT, 32'h8000_0000);
        send_request(FUNC_PUSH_BACK,  32'h0000_0000);
        send_request(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(FUNC_PUSH_BACK,  32'h0000_0005);
        send_request(FUNC_PUSH_FRONT, 32'h0000_0005);
        send_request(FUNC_SEARCH,     32'h0000_0005);  // two matches, front one wins
        send_request(FUNC_SEARCH,     32'h7FFF_FFFF);
        send_request(FUNC_SEARCH,     32'h8000_0000);
        send_request(FUNC_SEARCH,     32'h0000_0000);
        send_request(FUNC_SEARCH,     32'hFFFF_FFFF);
        send_request(FUNC_SEARCH,     32'h0000_0006);  // miss
        repeat (7)
            send_request(FUNC_POP_FRONT, 32'h0);       // last one hits empty
        send_request(FUNC_SEARCH,     32'h0000_0005);
    endtask

    // Fill to the limit from both ends, bounce off full, hit the last slot, drain
    task automatic test_full_queue();
        int n;
        send_gaps    = 1'b0;
        reply_stalls = 1'b0;
        n = 0;
        while (shadow_count < DEPTH)
        begin
            send_request((n % 2 == 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                         32'h1000_0000 + DATA_W'(n));
            n++;
        end
        send_request(FUNC_PUSH_FRONT, 32'h1234_5678);
        send_request(FUNC_PUSH_BACK,  32'h1234_5678);
        send_request(FUNC_SEARCH, shadow_mem[(shadow_front + DEPTH - 1) % DEPTH]);
        send_request(FUNC_SEARCH, shadow_mem[shadow_front]);
        send_request(FUNC_SEARCH, 32'h1234_5678);
        send_gaps    = 1'b1;
        reply_stalls = 1'b1;
        while (shadow_count > 0)
            send_request(FUNC_POP_FRONT, $urandom());
        send_request(FUNC_POP_FRONT, $urandom());
        hold_until_drained();
    endtask

    // Random phases; each ends by letting the result side catch up
    task automatic test_random_traffic();
        int    phase;
        int    k;
        int    roll;
        int    push_pct;
        int    pop_pct;
        mix_t  mix;
        for (phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++)
        begin
            mix = (phase % 5 < 2) ? MIX_GROW : (phase % 5 < 4) ? MIX_SHRINK : MIX_EVEN;
            case (mix)
                MIX_GROW:   begin push_pct = 55; pop_pct = 20; end
                MIX_SHRINK: begin push_pct = 25; pop_pct = 45; end
                default:    begin push_pct = 40; pop_pct = 25; end
            endcase
            send_gaps    = ($urandom_range(0, 3) != 0);
            reply_stalls = ($urandom_range(0, 3) != 0);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    send_request($urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT,
                                 pick_value());
                else if (roll < push_pct + pop_pct)
                    send_request(FUNC_POP_FRONT, $urandom());
                else
                    send_request(FUNC_SEARCH, pick_key());
            end
            hold_until_drained();
        end
    endtask

    // Main sequence
    initial
    begin
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        s_axis_tuser    <= FUNC_PUSH_FRONT;
        rst_n           <= 1'b0;
        send_gaps       = 1'b1;
        reply_stalls    = 1'b1;
        mismatches      = 0;
        replies_checked = 0;
        deepest_fill    = 0;
        shadow_front    = 0;
        shadow_count    = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (func_sent[i])
            func_sent[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_extremes();
        test_full_queue();
        test_random_traffic();

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d push front, %0d push back, %0d pop, %0d search",
            func_sent[FUNC_PUSH_FRONT] + func_sent[FUNC_PUSH_BACK]
            + func_sent[FUNC_POP_FRONT] + func_sent[FUNC_SEARCH],
            func_sent[FUNC_PUSH_FRONT], func_sent[FUNC_PUSH_BACK],
            func_sent[FUNC_POP_FRONT], func_sent[FUNC_SEARCH]);
        $display("Replies checked %0d (ok %0d, full %0d, empty %0d, not found %0d), peak fill %0d",
            replies_checked, status_seen[STAT_OK], status_seen[STAT_FULL],
            status_seen[STAT_EMPTY], status_seen[STAT_NOT_FOUND], deepest_fill);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
